### rtl/event_bank_tdc_hit_sorter_top_macros.svh
// ---------------------------------------------------------------------------
// Event bank hit sorter assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef EVENT_BANK_TDC_HIT_SORTER_TOP_MACROS_SVH
`define EVENT_BANK_TDC_HIT_SORTER_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define EBTHS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define EBTHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EBTHS_ASSERT_IMPL(lbl, ante, cons, msg)
`define EBTHS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/ebths_pkg.sv
// ---------------------------------------------------------------------------
// Event bank hit sorter package
// Shared types, codes and default sizes.
// ---------------------------------------------------------------------------
package ebths_pkg;

  localparam int unsigned NUM_CHANNELS_DEF  = 96;
  localparam int unsigned MAX_HITS_DEF      = 100;
  localparam int unsigned MAX_BANKS_DEF     = 32;
  localparam int unsigned POSITION_BITS_DEF = 16;

  // register indexes on the configuration port
  localparam logic [1:0] REG_BANK_SELECT    = 2'd0;
  localparam logic [1:0] REG_SLOT_SELECT    = 2'd1;
  localparam logic [1:0] REG_HEADER_PRESENT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_RANGE   = 2'd2,
    ST_LONG    = 2'd3
  } status_e;

  typedef enum logic {
    KIND_HIT = 1'b0,
    KIND_END = 1'b1
  } kind_e;

  typedef struct packed {
    logic [4:0] bank_select;
    logic [4:0] slot_select;
    logic       header_present;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [6:0]  channel;
    logic [6:0]  number;
    logic [15:0] value;
    logic [31:0] evn;
    status_e     status;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [1:0] n;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

  typedef struct packed {
    logic       en;
    logic [6:0] addr;
    logic [6:0] data;
  } cnt_wr_t;

endpackage

### rtl/ebths_cnt_mem.sv
// ---------------------------------------------------------------------------
// Per-channel hit counter memory
// Registered read issued when a word is taken, valid bits cleared per event,
// and a bypass for a write that lands on the same edge as the read.
// ---------------------------------------------------------------------------
module ebths_cnt_mem
  import ebths_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int unsigned MAX_HITS     = MAX_HITS_DEF,
  localparam int unsigned CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int unsigned CW  = $clog2(MAX_HITS)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rd_en_i,
  input  logic [CHW-1:0] rd_addr_i,
  input  cnt_wr_t        wr_i,
  input  logic           clr_i,
  output logic [CW-1:0]  cnt_o
);

  logic [CW-1:0]           mem_q [NUM_CHANNELS];
  logic [CW-1:0]           rd_q;
  logic [CHW-1:0]          rd_addr_q;
  logic [NUM_CHANNELS-1:0] valid_q;
  logic                    fwd_v_q;
  logic [CHW-1:0]          fwd_ch_q;
  logic [CW-1:0]           fwd_cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[CHW-1:0]] <= wr_i.data[CW-1:0];
    end
    if (rd_en_i) begin
      rd_q      <= mem_q[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
    if (wr_i.en) begin
      fwd_ch_q  <= wr_i.addr[CHW-1:0];
      fwd_cnt_q <= wr_i.data[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fwd_v_q <= 1'b0;
    end else if (clr_i) begin
      valid_q <= '0;
      fwd_v_q <= 1'b0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr[CHW-1:0]] <= 1'b1;
      fwd_v_q                     <= 1'b1;
    end
  end

  // latest write wins over the stale read; a cleared entry reads as zero
  always_comb begin
    if (fwd_v_q && (fwd_ch_q == rd_addr_q)) begin
      cnt_o = fwd_cnt_q;
    end else if (valid_q[rd_addr_q]) begin
      cnt_o = rd_q;
    end else begin
      cnt_o = '0;
    end
  end

endmodule

### rtl/ebths_parse.sv
// ---------------------------------------------------------------------------
// Event word parser
// Tracks word position and bank walk, picks hits of the selected slot and
// builds hit and end records for one word per cycle while proc_i is high.
// ---------------------------------------------------------------------------
`include "event_bank_tdc_hit_sorter_top_macros.svh"

module ebths_parse
  import ebths_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS  = NUM_CHANNELS_DEF,
  parameter int unsigned MAX_HITS      = MAX_HITS_DEF,
  parameter int unsigned MAX_BANKS     = MAX_BANKS_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  localparam int unsigned CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int unsigned CW  = $clog2(MAX_HITS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          proc_i,
  input  logic [31:0]   word_i,
  input  logic          sof_i,
  input  cfg_t          cfg_i,
  input  logic [CW-1:0] cnt_i,
  output cnt_wr_t       cnt_wr_o,
  output logic          clr_o,
  output push_t         push_o
);

  localparam int unsigned PB  = POSITION_BITS;
  localparam int unsigned SW  = ((PB > 32) ? PB : 32) + 2;
  localparam int unsigned BSW = $clog2(MAX_BANKS + 1);
  localparam logic [PB-1:0] PMAX = '1;

  function automatic logic [PB-1:0] sat_pos(input logic [SW-1:0] v);
    return (v > SW'(PMAX)) ? PMAX : v[PB-1:0];
  endfunction

  logic [PB-1:0]  wp_q, wp_d, el_q, el_d, nbp_q, nbp_d, bep_q, bep_d, pe_q, pe_d;
  logic           isb_q, isb_d, bf_q, bf_d, mws_q, mws_d, hd_q, hd_d;
  logic [BSW-1:0] bs_q, bs_d;
  status_e        err_q, err_d;
  logic [31:0]    eid_q, eid_d;

  logic [PB-1:0]  p;
  logic [PB:0]    p1;
  logic [6:0]     ch;
  logic [15:0]    val;
  logic [7:0]     id;
  logic           hit, endr;
  rec_t           hit_rec, end_rec;
  status_e        st;

  assign ch  = word_i[23:17];
  assign val = word_i[15:0];
  assign id  = word_i[23:16];

  always_comb begin
    wp_d  = wp_q;
    el_d  = el_q;
    nbp_d = nbp_q;
    bep_d = bep_q;
    pe_d  = pe_q;
    isb_d = isb_q;
    bf_d  = bf_q;
    mws_d = mws_q;
    hd_d  = hd_q;
    bs_d  = bs_q;
    err_d = err_q;
    eid_d = eid_q;
    hit   = 1'b0;
    endr  = 1'b0;
    p     = sof_i ? '0 : wp_q;
    p1    = {1'b0, p} + (PB+1)'(1);

    if (sof_i) begin
      nbp_d = PMAX;
      bep_d = '0;
      pe_d  = '0;
      isb_d = 1'b0;
      bf_d  = 1'b0;
      mws_d = 1'b0;
      hd_d  = 1'b0;
      bs_d  = '0;
      eid_d = '0;
      err_d = ST_OK;
      if (SW'(word_i) >= SW'(PMAX)) begin
        el_d  = PMAX;
        err_d = ST_LONG;
      end else begin
        el_d = PB'(word_i + 32'd1);
      end
    end

    if (p < el_d) begin
      if (p == PB'(2)) nbp_d = sat_pos(SW'(word_i) + SW'(3));
      if (p == PB'(4)) eid_d = word_i;

      if (err_d == ST_OK) begin
        // leave the bank once past its payload
        if (isb_d && (p > bep_d)) isb_d = 1'b0;

        if (isb_d && (word_i[31:27] == cfg_i.slot_select)) begin
          if (mws_d || !cfg_i.header_present) begin
            if (({1'b0, ch} < 8'(NUM_CHANNELS)) && (val != '0) &&
                (8'(cnt_i) < 8'(MAX_HITS - 1))) begin
              hit = 1'b1;
            end
          end
          mws_d = 1'b1;
        end

        if (hd_d) begin
          hd_d = 1'b0;
          if ({1'b0, id} >= 9'(MAX_BANKS)) begin
            err_d = ST_RANGE;
            isb_d = 1'b0;
          end else begin
            bs_d = bs_d + BSW'(1);
            if (id == {3'b000, cfg_i.bank_select}) begin
              bf_d  = 1'b1;
              isb_d = 1'b1;
              bep_d = pe_d;
            end
          end
        end

        // take a bank length word unless it is the event's last word or the bank limit is reached
        if ((err_d == ST_OK) && (p == nbp_d) && (p1 < {1'b0, el_d}) &&
            (bs_d < BSW'(MAX_BANKS))) begin
          pe_d  = sat_pos(SW'(p) + SW'(word_i));
          nbp_d = sat_pos(SW'(p) + SW'(word_i) + SW'(1));
          hd_d  = 1'b1;
        end
      end

      if (p1 == {1'b0, el_d}) endr = 1'b1;
    end

    wp_d = (p < PMAX) ? PB'(p1) : PMAX;
  end

  always_comb begin
    if (err_d != ST_OK) begin
      st = err_d;
    end else if (bf_d) begin
      st = ST_OK;
    end else begin
      st = ST_MISSING;
    end
  end

  always_comb begin
    hit_rec         = '0;
    hit_rec.kind    = KIND_HIT;
    hit_rec.channel = ch;
    hit_rec.number  = 7'(cnt_i);
    hit_rec.value   = val;
    hit_rec.status  = ST_OK;
    hit_rec.last    = !endr;

    end_rec        = '0;
    end_rec.kind   = KIND_END;
    end_rec.evn    = eid_d;
    end_rec.status = st;
    end_rec.last   = 1'b1;

    push_o.rec0 = hit ? hit_rec : end_rec;
    push_o.rec1 = end_rec;
    push_o.n    = proc_i ? ({1'b0, hit} + {1'b0, endr}) : 2'd0;

    cnt_wr_o.en   = proc_i && hit;
    cnt_wr_o.addr = 7'(ch[CHW-1:0]);
    cnt_wr_o.data = 7'(cnt_i + CW'(1));
    clr_o         = proc_i && sof_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      el_q  <= '0;
      nbp_q <= '0;
      bep_q <= '0;
      pe_q  <= '0;
      isb_q <= 1'b0;
      bf_q  <= 1'b0;
      mws_q <= 1'b0;
      hd_q  <= 1'b0;
      bs_q  <= '0;
      err_q <= ST_OK;
      eid_q <= '0;
    end else if (proc_i) begin
      wp_q  <= wp_d;
      el_q  <= el_d;
      nbp_q <= nbp_d;
      bep_q <= bep_d;
      pe_q  <= pe_d;
      isb_q <= isb_d;
      bf_q  <= bf_d;
      mws_q <= mws_d;
      hd_q  <= hd_d;
      bs_q  <= bs_d;
      err_q <= err_d;
      eid_q <= eid_d;
    end
  end

  `EBTHS_ASSERT_IMPL(a_err_stops_walk, err_q != ST_OK, !isb_q && !hd_q, "walk active after error")
  `EBTHS_ASSERT_IMPL(a_bank_bound, 1'b1, bs_q <= BSW'(MAX_BANKS), "bank count over limit")
  `EBTHS_ASSERT_IMPL(a_hit_in_range, cnt_wr_o.en, ({1'b0, ch} < 8'(NUM_CHANNELS)) && (val != '0), "hit on bad channel or zero value")

endmodule

### rtl/ebths_out_fifo.sv
// ---------------------------------------------------------------------------
// Output record queue
// Four-entry queue taking up to two records a cycle, draining one.
// ---------------------------------------------------------------------------
`include "event_bank_tdc_hit_sorter_top_macros.svh"

module ebths_out_fifo
  import ebths_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output rec_t  head_o,
  output logic  valid_o,
  input  logic  ready_i
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  rec_t          buf_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   count_q;
  logic          pop;

  assign pop     = (count_q != '0) && ready_i;
  assign valid_o = (count_q != '0);
  assign head_o  = buf_q[rd_q];
  // hold new words until two entries are free
  assign room_o  = (count_q <= (AW+1)'(DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) buf_q[wr_q] <= push_i.rec0;
    if (push_i.n == 2'd2) buf_q[wr_q + AW'(1)] <= push_i.rec1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + AW'(push_i.n);
      rd_q    <= rd_q + AW'(pop);
      count_q <= count_q + (AW+1)'(push_i.n) - (AW+1)'(pop);
    end
  end

  `EBTHS_ASSERT_IMPL(a_fifo_bound, 1'b1, count_q <= (AW+1)'(DEPTH), "queue overflow")
  `EBTHS_ASSERT_IMPL(a_two_fit, push_i.n == 2'd2, room_o, "double request without room")
  `EBTHS_ASSERT_NEXT(a_count_track, 1'b1, count_q == $past(count_q) + (AW+1)'($past(push_i.n)) - (AW+1)'($past(pop)), "queue count mismatch")

endmodule

### rtl/event_bank_tdc_hit_sorter_top.sv
// ---------------------------------------------------------------------------
// Event bank hit sorter
// Walks the banks of each event word stream and emits per-channel hits of the
// selected bank and slot, followed by an end-of-event status record.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake                 | contents
//  s_axis   | in  | tvalid/tready             | tdata event_word, tuser start_of_event
//  m_axis   | out | tvalid/tready, tlast      | tdata hit/end fields, tuser record_kind
//  apb      | in  | psel/penable, pready high | bank_select, slot_select, header_present
//
// One word is taken per cycle while the queue has room; it sits in the input register while the
// channel count read completes, then parser results enter a four-entry queue.
// A word that causes two records fills two queue entries; the queue drains one
// record per cycle while m_axis_tready_i is high.
// Input is held off only while fewer than two queue entries are free.
// Reset clears control state and sets all three registers to 1.
// ---------------------------------------------------------------------------
module event_bank_tdc_hit_sorter_top
  import ebths_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS  = NUM_CHANNELS_DEF,
  parameter int unsigned MAX_HITS      = MAX_HITS_DEF,
  parameter int unsigned MAX_BANKS     = MAX_BANKS_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: [31:0] event_word
  input  logic [31:0] s_axis_tdata_i,
  // tuser: [0] start_of_event
  input  logic        s_axis_tuser_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: [6:0] hit_channel, [13:7] hit_number, [29:14] hit_value,
  //        [61:30] event_number, [63:62] event_status
  output logic [63:0] m_axis_tdata_o,
  // tuser: [0] record_kind
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CW  = $clog2(MAX_HITS);

  cfg_t          cfg_q;
  logic          inv_q;
  logic [31:0]   word_q;
  logic          sof_q;
  logic          proc, accept, room, rd_en;
  logic [CW-1:0] cnt;
  cnt_wr_t       cnt_wr;
  logic          clr;
  push_t         push;
  rec_t          head;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bank_select    <= 5'd1;
      cfg_q.slot_select    <= 5'd1;
      cfg_q.header_present <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_BANK_SELECT:    cfg_q.bank_select    <= pwdata[4:0];
        REG_SLOT_SELECT:    cfg_q.slot_select    <= pwdata[4:0];
        REG_HEADER_PRESENT: cfg_q.header_present <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BANK_SELECT:    prdata = {27'd0, cfg_q.bank_select};
      REG_SLOT_SELECT:    prdata = {27'd0, cfg_q.slot_select};
      REG_HEADER_PRESENT: prdata = {31'd0, cfg_q.header_present};
      default:            prdata = '0;
    endcase
  end

  // input register
  assign proc            = inv_q && room;
  assign s_axis_tready_o = !inv_q || proc;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign rd_en           = accept && ({1'b0, s_axis_tdata_i[23:17]} < 8'(NUM_CHANNELS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
    end else if (accept) begin
      inv_q <= 1'b1;
    end else if (proc) begin
      inv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= s_axis_tdata_i;
      sof_q  <= s_axis_tuser_i;
    end
  end

  ebths_cnt_mem #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .MAX_HITS    (MAX_HITS)
  ) u_cnt_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(s_axis_tdata_i[17 +: CHW]),
    .wr_i     (cnt_wr),
    .clr_i    (clr),
    .cnt_o    (cnt)
  );

  ebths_parse #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_HITS     (MAX_HITS),
    .MAX_BANKS    (MAX_BANKS),
    .POSITION_BITS(POSITION_BITS)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .proc_i  (proc),
    .word_i  (word_q),
    .sof_i   (sof_q),
    .cfg_i   (cfg_q),
    .cnt_i   (cnt),
    .cnt_wr_o(cnt_wr),
    .clr_o   (clr),
    .push_o  (push)
  );

  ebths_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .head_o (head),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i)
  );

  assign m_axis_tdata_o = {head.status, head.evn, head.value, head.number, head.channel};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule
